>>> design/ucpe_pkg.sv
// Shared types, constants and helper functions for the UTF-8 code point escaper.
// Used by ucpe_decode, ucpe_emit and utf8_codepoint_escaper_unit; no dependencies.
package ucpe_pkg;

  localparam logic [7:0] ESC_CHAR   = 8'h5F;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;

  // Lead bytes that narrow the first continuation byte
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hBF;

  // Kind of result group produced by one input item
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_ESC  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One group of results, handed from the decoder to the output serializer
  typedef struct packed {
    kind_t            kind;
    logic [3:0][7:0]  bytes;     // original sequence bytes, first byte in [0]
    logic [3:0]       count;     // number of result bytes in the group
    logic [20:0]      cp;        // code point for the decimal escape
    logic [2:0]       pow;       // power of ten of the leading digit
    logic             word_end;
  } group_t;

  // Letter, digit and listed-block test on a code point
  function automatic logic in_ranges(input logic [20:0] cp);
    logic hit;
    hit = (cp >= 21'h00041 && cp <= 21'h0005A) ||
          (cp >= 21'h00061 && cp <= 21'h0007A) ||
          (cp >= 21'h00030 && cp <= 21'h00039) ||
          (cp >= 21'h000C0 && cp <= 21'h000D6) ||
          (cp >= 21'h000D8 && cp <= 21'h000F6) ||
          (cp >= 21'h000F8 && cp <= 21'h002FF) ||
          (cp >= 21'h00370 && cp <= 21'h0037D) ||
          (cp >= 21'h0037F && cp <= 21'h01FFF) ||
          (cp >= 21'h0200C && cp <= 21'h0200D) ||
          (cp >= 21'h02070 && cp <= 21'h0218F) ||
          (cp >= 21'h02C00 && cp <= 21'h02FEF) ||
          (cp >= 21'h03001 && cp <= 21'h0D7FF) ||
          (cp >= 21'h0F900 && cp <= 21'h0FDCF) ||
          (cp >= 21'h0FDF0 && cp <= 21'h0FFFD) ||
          (cp >= 21'h10000 && cp <= 21'hEFFFF);
    return hit;
  endfunction

  // Number of decimal digits of a code point, 1 to 7
  function automatic logic [2:0] num_digits(input logic [20:0] cp);
    logic [2:0] nd;
    nd = 3'd1;
    if (cp >= 21'd10)      nd = 3'd2;
    if (cp >= 21'd100)     nd = 3'd3;
    if (cp >= 21'd1000)    nd = 3'd4;
    if (cp >= 21'd10000)   nd = 3'd5;
    if (cp >= 21'd100000)  nd = 3'd6;
    if (cp >= 21'd1000000) nd = 3'd7;
    return nd;
  endfunction

  // Power of ten selected by digit position
  function automatic logic [23:0] pow10(input logic [2:0] i);
    logic [23:0] p;
    case (i)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

endpackage

>>> design/utf8_codepoint_escaper_unit.sv
// Top level of the UTF-8 code point escaper: stream ports, decoder and serializer.
// Depends on ucpe_pkg, ucpe_decode and ucpe_emit.
//
// Takes one byte of a UTF-8 word per cycle while the serializer is free, decodes
// strict UTF-8 and writes the escaped text one byte per cycle unless m_tready
// holds it. A code point in a letter, digit or listed block comes out as its
// original bytes; any other one as an underscore, its decimal value and an
// underscore; a bad or cut-off sequence as one error item with a zero byte. An
// input byte that completes nothing gives no output. A byte that yields k output
// items (1 to 9) holds the serializer until the last of them is sent, and the
// next byte, whether it yields output or not, is taken as that last item goes,
// so plain text flows at one byte per cycle when the output does not stall. The
// serializer's single output byte per cycle sets that figure. tuser on the
// output carries run_last in bit 0 and error in bit 1.
module utf8_codepoint_escaper_unit
  import ucpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] in_byte
  input  logic        s_tlast,    // word_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_byte
  output logic        m_tlast,    // word_done
  output logic [1:0]  m_tuser     // [0] run_last, [1] error
);

  logic   accept;
  logic   grp_has;
  logic   free;
  group_t grp;

  assign s_tready = free;
  assign accept   = s_tvalid && s_tready;

  // Decoder
  ucpe_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (s_tdata),
    .word_end (s_tlast),
    .grp_has  (grp_has),
    .grp      (grp)
  );

  // Serializer and output register
  ucpe_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && grp_has),
    .grp      (grp),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> design/ucpe_decode.sv
// Strict UTF-8 decoder: sequence state and per-item result group.
// Depends on ucpe_pkg.
module ucpe_decode
  import ucpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,     // input item taken this cycle
  input  logic [7:0]  in_byte,
  input  logic        word_end,
  output logic        grp_has,    // item yields at least one result
  output group_t      grp
);

  logic [2:0]  seen;
  logic [2:0]  expct;
  logic [20:0] code;
  logic [7:0]  held [0:2];

  logic [2:0]  seen_next;
  logic [2:0]  expct_next;
  logic [20:0] code_next;
  logic        held_we;
  logic [1:0]  held_idx;

  logic        start;
  logic        complete;
  logic        fail;
  logic [20:0] cp_val;
  logic [2:0]  len_val;
  logic [3:0][7:0] bytes_val;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [20:0] cont_code;
  logic [2:0]  seen_inc;
  logic [2:0]  nd;

  // Lead and continuation decode
  always_comb begin
    seen_next  = seen;
    expct_next = expct;
    code_next  = code;
    held_we    = 1'b0;
    held_idx   = seen[1:0];
    start      = 1'b0;
    complete   = 1'b0;
    fail       = 1'b0;
    cp_val     = code;
    len_val    = 3'd1;
    bytes_val  = '0;
    lo         = CONT_LO;
    hi         = CONT_HI;
    cont_code  = {code[14:0], in_byte[5:0]};
    seen_inc   = seen + 3'd1;
    if (expct == 3'd0) begin
      if (in_byte < 8'h80) begin
        complete     = 1'b1;
        cp_val       = {13'd0, in_byte};
        len_val      = 3'd1;
        bytes_val[0] = in_byte;
      end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
        start      = 1'b1;
        expct_next = 3'd2;
        code_next  = {16'd0, in_byte[4:0]};
      end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
        start      = 1'b1;
        expct_next = 3'd3;
        code_next  = {17'd0, in_byte[3:0]};
      end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
        start      = 1'b1;
        expct_next = 3'd4;
        code_next  = {18'd0, in_byte[2:0]};
      end else begin
        fail = 1'b1;
      end
      if (start) begin
        held_we   = 1'b1;
        held_idx  = 2'd0;
        seen_next = 3'd1;
        if (word_end) begin
          fail       = 1'b1;
          seen_next  = 3'd0;
          expct_next = 3'd0;
          code_next  = '0;
        end
      end
    end else begin
      // first continuation byte narrowed by the lead byte
      if (seen == 3'd1) begin
        if (held[0] == LEAD_E0)      lo = 8'hA0;
        else if (held[0] == LEAD_ED) hi = 8'h9F;
        else if (held[0] == LEAD_F0) lo = 8'h90;
        else if (held[0] == LEAD_F4) hi = 8'h8F;
      end
      if (in_byte < lo || in_byte > hi) begin
        fail       = 1'b1;
        seen_next  = 3'd0;
        expct_next = 3'd0;
        code_next  = '0;
      end else if (seen_inc >= expct) begin
        complete     = 1'b1;
        cp_val       = cont_code;
        len_val      = seen_inc;
        bytes_val[0] = held[0];
        bytes_val[1] = held[1];
        bytes_val[2] = held[2];
        bytes_val[seen[1:0]] = in_byte;
        seen_next    = 3'd0;
        expct_next   = 3'd0;
        code_next    = '0;
      end else begin
        held_we   = 1'b1;
        seen_next = seen_inc;
        code_next = cont_code;
        if (word_end) begin
          fail       = 1'b1;
          seen_next  = 3'd0;
          expct_next = 3'd0;
          code_next  = '0;
        end
      end
    end
  end

  // Result group for the serializer
  assign nd = num_digits(cp_val);

  always_comb begin
    grp_has      = fail || complete;
    grp.bytes    = bytes_val;
    grp.cp       = cp_val;
    grp.pow      = nd - 3'd1;
    grp.word_end = word_end;
    if (fail) begin
      grp.kind  = KIND_ERR;
      grp.count = 4'd1;
    end else if (in_ranges(cp_val)) begin
      grp.kind  = KIND_PASS;
      grp.count = {1'b0, len_val};
    end else begin
      grp.kind  = KIND_ESC;
      grp.count = {1'b0, nd} + 4'd2;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      expct <= '0;
      code  <= '0;
    end else if (accept) begin
      seen  <= seen_next;
      expct <= expct_next;
      code  <= code_next;
    end
  end

  // Held sequence bytes, no reset
  always_ff @(posedge clk) begin
    if (accept && held_we && held_idx != 2'd3) begin
      held[held_idx] <= in_byte;
    end
  end

endmodule

>>> design/ucpe_emit.sv
// Output serializer: group register, decimal digit generation and output register.
// Depends on ucpe_pkg.
module ucpe_emit
  import ucpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,       // new group from the decoder
  input  group_t      grp,
  output logic        free,       // group register can take a group this cycle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_byte
  output logic        m_tlast,    // word_done
  output logic [1:0]  m_tuser     // [0] run_last, [1] error
);

  logic        gvalid;
  group_t      g;
  logic [3:0]  gidx;
  logic [20:0] grem;
  logic [2:0]  gpow;

  logic        emit;
  logic        last;
  logic        gdone;
  logic        digit_phase;
  logic [23:0] pw;
  logic [23:0] mult;
  logic [23:0] sub;
  logic [3:0]  dig;
  logic [20:0] grem_next;
  logic [7:0]  byte_sel;

  assign emit  = gvalid && (!m_tvalid || m_tready);
  assign last  = (gidx == g.count - 4'd1);
  assign gdone = emit && last;
  assign free  = !gvalid || gdone;

  assign digit_phase = (g.kind == KIND_ESC) && (gidx != 4'd0) && !last;

  // Leading digit of the remainder at the current power of ten
  always_comb begin
    pw   = pow10(gpow);
    sub  = '0;
    dig  = '0;
    mult = '0;
    for (int k = 1; k <= 9; k++) begin
      mult = pw * 24'(k);
      if ({3'd0, grem} >= mult) begin
        sub = mult;
        dig = 4'(k);
      end
    end
    grem_next = grem - sub[20:0];
  end

  // Byte for the current position of the group
  always_comb begin
    case (g.kind)
      KIND_PASS: byte_sel = g.bytes[gidx[1:0]];
      KIND_ESC:  byte_sel = digit_phase ? (DIGIT_ZERO + {4'd0, dig}) : ESC_CHAR;
      default:   byte_sel = 8'd0;
    endcase
  end

  // Group register control
  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= 1'b0;
    end else if (load) begin
      gvalid <= 1'b1;
    end else if (gdone) begin
      gvalid <= 1'b0;
    end
  end

  // Group payload and position
  always_ff @(posedge clk) begin
    if (load) begin
      g    <= grp;
      gidx <= '0;
      grem <= grp.cp;
      gpow <= grp.pow;
    end else if (emit) begin
      gidx <= gidx + 4'd1;
      if (digit_phase) begin
        grem <= grem_next;
        gpow <= gpow - 3'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata    <= byte_sel;
      m_tlast    <= last && g.word_end;
      m_tuser[0] <= last;
      m_tuser[1] <= (g.kind == KIND_ERR);
    end
  end

endmodule
